// ===== hw/rtl/rvli_pkg.sv =====
// shared types and constants of the ray volume line integral block
// no dependencies; used by rvli_div, rvli_sqrt and the top level
`default_nettype none
package rvli_pkg;

  // default volume extents per axis
  localparam int MAX_X_DEF = 64;
  localparam int MAX_Y_DEF = 64;
  localparam int MAX_Z_DEF = 64;

  // per-ray result store
  localparam int SLICE_DEPTH = 64;
  localparam int SLICE_AW    = 6;

  // configuration register indexes
  localparam logic [2:0] CFG_SIZE_X  = 3'd0;
  localparam logic [2:0] CFG_SIZE_Y  = 3'd1;
  localparam logic [2:0] CFG_SIZE_Z  = 3'd2;
  localparam logic [2:0] CFG_PITCH   = 3'd3;
  localparam logic [2:0] CFG_PLANAR  = 3'd4;
  localparam logic [2:0] CFG_SLICES  = 3'd5;

  // input item kinds
  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_RAY  = 1'b1;

  // fixed point constants
  localparam logic [31:0] ONE_Q31 = 32'h8000_0000;
  localparam logic [47:0] SUM_MAX = 48'hFFFF_FFFF_FFFF;

  // datapath widths
  localparam int MUL_W    = 35;
  localparam int DIV_RW   = 34;
  localparam int DIV_NB   = 8;
  localparam int DIV_QW   = 31;
  localparam int SQ_W     = 67;
  localparam int ROOT_W   = 35;

  // iteration counts of the shared units
  localparam logic [4:0] ALPHA_STEPS = 5'd31;
  localparam logic [4:0] INDEX_STEPS = 5'd8;
  localparam logic [5:0] ROOT_STEPS  = 6'd35;

  typedef struct packed {
    logic       start;
    logic [4:0] steps;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage
`default_nettype wire

// ===== hw/rtl/rvli_ram.sv =====
// generic simple dual-port ram with registered read
// no dependencies
`default_nettype none
module rvli_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== hw/rtl/rvli_div.sv =====
// iterative restoring divider, one quotient bit per cycle
// depends on rvli_pkg
`default_nettype none
module rvli_div (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire rvli_pkg::div_req_t              req,
  input  wire logic [rvli_pkg::DIV_RW-1:0]     num_hi,
  input  wire logic [rvli_pkg::DIV_NB-1:0]     num_lo,
  input  wire logic [rvli_pkg::DIV_RW-1:0]     den,
  output rvli_pkg::unit_stat_t                 stat,
  output logic      [rvli_pkg::DIV_QW-1:0]     quot
);

  logic [rvli_pkg::DIV_RW-1:0] rem;
  logic [rvli_pkg::DIV_NB-1:0] lo_bits;
  logic [rvli_pkg::DIV_RW-1:0] den_r;
  logic [4:0]                  cnt;
  logic                        busy;
  logic                        done;
  logic [rvli_pkg::DIV_RW:0]   trial;
  logic                        ge;
  logic [rvli_pkg::DIV_RW-1:0] rem_next;

  // shift in the next numerator bit and try a subtract
  always_comb begin
    trial    = {rem, lo_bits[rvli_pkg::DIV_NB-1]};
    ge       = trial >= {1'b0, den_r};
    rem_next = ge ? rvli_pkg::DIV_RW'(trial - {1'b0, den_r})
                  : trial[rvli_pkg::DIV_RW-1:0];
  end

  // step control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= req.steps;
      end else if (busy) begin
        cnt <= cnt - 5'd1;
        if (cnt == 5'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // remainder and quotient
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem     <= num_hi;
      lo_bits <= num_lo;
      den_r   <= den;
      quot    <= '0;
    end else if (busy) begin
      rem     <= rem_next;
      lo_bits <= {lo_bits[rvli_pkg::DIV_NB-2:0], 1'b0};
      quot    <= {quot[rvli_pkg::DIV_QW-2:0], ge};
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;

endmodule
`default_nettype wire

// ===== hw/rtl/rvli_sqrt.sv =====
// iterative integer square root, one root bit per cycle
// depends on rvli_pkg
`default_nettype none
module rvli_sqrt (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic [rvli_pkg::SQ_W-1:0]     value,
  output rvli_pkg::unit_stat_t               stat,
  output logic      [rvli_pkg::ROOT_W-1:0]   root
);

  localparam int VW = 2 * rvli_pkg::ROOT_W;
  localparam int RW = rvli_pkg::ROOT_W + 2;

  logic [VW-1:0] vreg;
  logic [RW-1:0] rem;
  logic [5:0]    cnt;
  logic          busy;
  logic          done;
  logic [RW-1:0] rem_sh;
  logic [RW-1:0] trial;
  logic          ge;

  // bring down the next bit pair and try the odd subtrahend
  always_comb begin
    rem_sh = {rem[RW-3:0], vreg[VW-1 -: 2]};
    trial  = {root, 2'b01};
    ge     = rem_sh >= trial;
  end

  // step control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= rvli_pkg::ROOT_STEPS;
      end else if (busy) begin
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // remainder and root
  always_ff @(posedge clk) begin
    if (start) begin
      vreg <= VW'(value);
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      vreg <= {vreg[VW-3:0], 2'b00};
      rem  <= ge ? rem_sh - trial : rem_sh;
      root <= {root[rvli_pkg::ROOT_W-2:0], ge};
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;

endmodule
`default_nettype wire

// ===== hw/rtl/ray_volume_line_integral.sv =====
// top level of the ray volume line integral (forward projector)
// depends on rvli_pkg, rvli_ram, rvli_div, rvli_sqrt
//
// Usage:
//  in channel (in_valid/in_ready): kind 0 writes voxel_value at
//  voxel_address (no result; addresses beyond the volume are
//  dropped); kind 1 traces the ray from src to det through the volume.
//  out channel (out_valid/out_ready): one result per ray in 3-D mode, or
//  slice_count results (1..64) in planar mode, last on the final one.
//  cfg channel (cfg_valid/cfg_ready): always ready, write only when idle.
//  Per ray the block finds the entry and exit bounds, each grid-plane
//  crossing parameter (shared divider), the voxel index per axis per
//  segment (shared divider) and, per slice per segment, does the memory
//  read, multiply and accumulate; the ray length comes from the square
//  root, and each result takes one output transfer.
//  in_ready is low from ray acceptance until the last result transfer.
//  A stalled receiver holds the block in its output state.
//  Reset returns the sequencer to idle and the registers to defaults;
//  the volume contents are kept and are undefined until written.
`default_nettype none
module ray_volume_line_integral #(
  parameter int MAX_X = rvli_pkg::MAX_X_DEF,
  parameter int MAX_Y = rvli_pkg::MAX_Y_DEF,
  parameter int MAX_Z = rvli_pkg::MAX_Z_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               kind,
  input  wire logic [17:0]        voxel_address,
  input  wire logic [15:0]        voxel_value,
  input  wire logic signed [31:0] src_x,
  input  wire logic signed [31:0] src_y,
  input  wire logic signed [31:0] src_z,
  input  wire logic signed [31:0] det_x,
  input  wire logic signed [31:0] det_y,
  input  wire logic signed [31:0] det_z,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [47:0]             line_integral,
  output logic [5:0]              slice_index,
  output logic                    last,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [31:0]        cfg_data
);

  localparam int VOL_DEPTH = MAX_X * MAX_Y * MAX_Z;
  localparam int VA_W = (VOL_DEPTH > 1) ? $clog2(VOL_DEPTH) : 1;

  // sequencer states
  localparam logic [5:0] ST_IDLE    = 6'd0;
  localparam logic [5:0] ST_SQ_MUL  = 6'd1;
  localparam logic [5:0] ST_SQ_ACC  = 6'd2;
  localparam logic [5:0] ST_SQRT    = 6'd3;
  localparam logic [5:0] ST_PN_MUL  = 6'd4;
  localparam logic [5:0] ST_PN_ST   = 6'd5;
  localparam logic [5:0] ST_PS_MUL  = 6'd6;
  localparam logic [5:0] ST_PS_ST   = 6'd7;
  localparam logic [5:0] ST_BND     = 6'd8;
  localparam logic [5:0] ST_BND_F   = 6'd9;
  localparam logic [5:0] ST_BND_L   = 6'd10;
  localparam logic [5:0] ST_AL_MUL  = 6'd11;
  localparam logic [5:0] ST_AL_NUM  = 6'd12;
  localparam logic [5:0] ST_AL_DIV  = 6'd13;
  localparam logic [5:0] ST_INIT    = 6'd14;
  localparam logic [5:0] ST_INIT_ST = 6'd15;
  localparam logic [5:0] ST_SEL     = 6'd16;
  localparam logic [5:0] ST_SEG     = 6'd17;
  localparam logic [5:0] ST_IX_MUL  = 6'd18;
  localparam logic [5:0] ST_IX_REL  = 6'd19;
  localparam logic [5:0] ST_IX_DIV  = 6'd20;
  localparam logic [5:0] ST_AD_SUM  = 6'd21;
  localparam logic [5:0] ST_AD3_MUL = 6'd22;
  localparam logic [5:0] ST_AD3_SUM = 6'd23;
  localparam logic [5:0] ST_SL_MUL  = 6'd24;
  localparam logic [5:0] ST_SL_ST   = 6'd25;
  localparam logic [5:0] ST_ACC_RD  = 6'd26;
  localparam logic [5:0] ST_ACC_MUL = 6'd27;
  localparam logic [5:0] ST_ACC_WR  = 6'd28;
  localparam logic [5:0] ST_ADV     = 6'd29;
  localparam logic [5:0] ST_ADV_ST  = 6'd30;
  localparam logic [5:0] ST_OUT_RD  = 6'd31;
  localparam logic [5:0] ST_OUT_LD  = 6'd32;
  localparam logic [5:0] ST_OUT_SHOW = 6'd33;

  // configuration registers
  logic [6:0]  size_x, size_y, size_z, slice_count;
  logic [30:0] voxel_pitch;
  logic        planar_mode;

  // per-ray registers
  logic [5:0]         state;
  logic [5:0]         ret;
  logic [1:0]         ax;
  logic [1:0]         sel;
  logic               planar_r;
  logic [6:0]         slices;
  logic [6:0]         kend;
  logic [6:0]         k;
  logic signed [31:0] s_reg [3];
  logic [32:0]        dmag [3];
  logic [2:0]         dneg;
  logic [2:0]         dnz;
  logic [39:0]        pn [3];
  logic [16:0]        plane_sz;
  logic [rvli_pkg::SQ_W-1:0]   sqacc;
  logic [rvli_pkg::ROOT_W-1:0] len;
  logic [31:0]        amin, amax, prev, cur, ftmp, al_res;
  logic [31:0]        cand [3];
  logic [8:0]         m_r [3];
  logic [2:0]         done;
  logic [8:0]         al_m;
  logic               fin_seg;
  logic [32:0]        asum;
  logic [7:0]         idx [3];
  logic [VA_W-1:0]    ad;
  logic [34:0]        sl;
  logic [rvli_pkg::SLICE_DEPTH-1:0] sum_vld;

  // shared multiplier
  logic signed [rvli_pkg::MUL_W-1:0]   mul_a, mul_b;
  logic signed [2*rvli_pkg::MUL_W-1:0] prod;

  // unit interfaces
  rvli_pkg::div_req_t   div_req;
  rvli_pkg::unit_stat_t div_stat;
  rvli_pkg::unit_stat_t sq_stat;
  logic [rvli_pkg::DIV_RW-1:0] div_hi, div_den;
  logic [rvli_pkg::DIV_NB-1:0] div_lo;
  logic [rvli_pkg::DIV_QW-1:0] div_q;
  logic                        sq_start;
  logic [rvli_pkg::ROOT_W-1:0] sq_root;

  // memories
  logic            vol_we;
  logic [15:0]     vol_rd;
  logic            sum_we;
  logic [47:0]     sum_rd;
  logic [47:0]     sum_new;

  // combinational helpers
  logic [8:0]          dim [3];
  logic [1:0]          naxes;
  logic                in_acc;
  logic signed [32:0]  dfull [3];
  logic signed [41:0]  num;
  logic [41:0]         nmag;
  logic [33:0]         den2;
  logic signed [42:0]  rel;
  logic [34:0]         off;
  logic                sel_ok;
  logic [1:0]          sel_ax;
  logic [31:0]         sel_c;
  logic [49:0]         sum_wide;
  logic [47:0]         sum_old;
  logic signed [10:0]  twom_n;
  logic [8:0]          m_step;

  // axis extents clipped to the volume
  always_comb begin
    dim[0] = ({2'b0, size_x} > 9'(MAX_X)) ? 9'(MAX_X) : {2'b0, size_x};
    dim[1] = ({2'b0, size_y} > 9'(MAX_Y)) ? 9'(MAX_Y) : {2'b0, size_y};
    dim[2] = ({2'b0, size_z} > 9'(MAX_Z)) ? 9'(MAX_Z) : {2'b0, size_z};
  end

  assign naxes     = planar_r ? 2'd2 : 2'd3;
  assign in_ready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid && in_ready;
  assign out_valid = (state == ST_OUT_SHOW);

  // ray direction from the input transfer
  always_comb begin
    dfull[0] = {det_x[31], det_x} - {src_x[31], src_x};
    dfull[1] = {det_y[31], det_y} - {src_y[31], src_y};
    dfull[2] = {det_z[31], det_z} - {src_z[31], src_z};
  end

  // crossing parameter numerator and denominator
  always_comb begin
    twom_n = $signed({1'b0, al_m, 1'b0}) - $signed({2'b0, dim[ax]});
    num    = prod[41:0] - 42'($signed({s_reg[ax], 1'b0}));
    nmag   = num[41] ? 42'(-num) : 42'(num);
    den2   = {dmag[ax], 1'b0};
  end

  // midpoint position relative to the low face, doubled
  always_comb begin
    off = prod[65:31];
    if (dneg[ax]) begin
      rel = 43'($signed({s_reg[ax], 1'b0})) - $signed({8'b0, off})
            + $signed({3'b0, pn[ax]});
    end else begin
      rel = 43'($signed({s_reg[ax], 1'b0})) + $signed({8'b0, off})
            + $signed({3'b0, pn[ax]});
    end
  end

  // pick the pending crossing with the smallest parameter
  always_comb begin
    sel_ok = 1'b0;
    sel_ax = 2'd0;
    sel_c  = '0;
    for (int a = 0; a < 3; a++) begin
      if (!done[a] && (!sel_ok || cand[a] < sel_c)) begin
        sel_ok = 1'b1;
        sel_ax = 2'(a);
        sel_c  = cand[a];
      end
    end
  end

  // next plane index along the advancing axis
  assign m_step = dneg[sel] ? m_r[sel] - 9'd1 : m_r[sel] + 9'd1;

  // saturating accumulate
  always_comb begin
    sum_old  = sum_vld[k[rvli_pkg::SLICE_AW-1:0]] ? sum_rd : '0;
    sum_wide = {2'b0, sum_old} + prod[49:0];
    sum_new  = (sum_wide > {2'b0, rvli_pkg::SUM_MAX}) ? rvli_pkg::SUM_MAX
                                                     : sum_wide[47:0];
  end

  // multiplier operand selection
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      ST_SQ_MUL: begin
        mul_a = $signed({2'b0, dmag[ax]});
        mul_b = $signed({2'b0, dmag[ax]});
      end
      ST_PN_MUL: begin
        mul_a = $signed({4'b0, voxel_pitch});
        mul_b = $signed({26'b0, dim[ax]});
      end
      ST_PS_MUL: begin
        mul_a = $signed({26'b0, dim[0]});
        mul_b = $signed({26'b0, dim[1]});
      end
      ST_AL_MUL: begin
        mul_a = $signed({4'b0, voxel_pitch});
        mul_b = rvli_pkg::MUL_W'(twom_n);
      end
      ST_IX_MUL: begin
        if (ax == naxes) begin
          mul_a = $signed({27'b0, idx[1]});
          mul_b = $signed({26'b0, dim[0]});
        end else begin
          mul_a = $signed({2'b0, asum});
          mul_b = $signed({2'b0, dmag[ax]});
        end
      end
      ST_AD3_MUL: begin
        mul_a = $signed({27'b0, idx[2]});
        mul_b = $signed({18'b0, plane_sz});
      end
      ST_SL_MUL: begin
        mul_a = $signed({3'b0, cur - prev});
        mul_b = $signed(len);
      end
      ST_ACC_MUL: begin
        mul_a = $signed({19'b0, vol_rd});
        mul_b = $signed(sl);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // divider and square root requests
  always_comb begin
    div_req.start = 1'b0;
    div_req.steps = rvli_pkg::ALPHA_STEPS;
    div_hi        = nmag[33:0];
    div_lo        = '0;
    div_den       = den2;
    if (state == ST_AL_NUM) begin
      div_req.start = !(num == '0 || num[41] != dneg[ax] || nmag >= {8'b0, den2});
    end else if (state == ST_IX_REL) begin
      div_req.start = !(rel[42] || rel >= $signed({2'b0, pn[ax], 1'b0}));
      div_req.steps = rvli_pkg::INDEX_STEPS;
      div_hi        = rel[41:8];
      div_lo        = rel[7:0];
      div_den       = {2'b0, voxel_pitch, 1'b0};
    end
  end

  assign sq_start = (state == ST_SQ_MUL) && (ax == naxes);
  assign vol_we   = in_acc && (kind == rvli_pkg::KIND_LOAD)
                    && ({14'b0, voxel_address} < 32'(VOL_DEPTH));
  assign sum_we   = (state == ST_ACC_WR);

  rvli_div u_div (
    .clk    (clk),
    .rst    (rst),
    .req    (div_req),
    .num_hi (div_hi),
    .num_lo (div_lo),
    .den    (div_den),
    .stat   (div_stat),
    .quot   (div_q)
  );

  rvli_sqrt u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sq_start),
    .value (sqacc),
    .stat  (sq_stat),
    .root  (sq_root)
  );

  rvli_ram #(.WIDTH(16), .DEPTH(VOL_DEPTH)) u_vol (
    .clk   (clk),
    .we    (vol_we),
    .waddr (VA_W'(voxel_address)),
    .wdata (voxel_value),
    .raddr (ad),
    .rdata (vol_rd)
  );

  rvli_ram #(.WIDTH(48), .DEPTH(rvli_pkg::SLICE_DEPTH)) u_sums (
    .clk   (clk),
    .we    (sum_we),
    .waddr (k[rvli_pkg::SLICE_AW-1:0]),
    .wdata (sum_new),
    .raddr (k[rvli_pkg::SLICE_AW-1:0]),
    .rdata (sum_rd)
  );

  // configuration writes, sequencer and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      size_x      <= 7'd64;
      size_y      <= 7'd64;
      size_z      <= 7'd64;
      voxel_pitch <= 31'd65536;
      planar_mode <= 1'b0;
      slice_count <= 7'd64;
      sum_vld     <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          rvli_pkg::CFG_SIZE_X: size_x      <= cfg_data[6:0];
          rvli_pkg::CFG_SIZE_Y: size_y      <= cfg_data[6:0];
          rvli_pkg::CFG_SIZE_Z: size_z      <= cfg_data[6:0];
          rvli_pkg::CFG_PITCH:  voxel_pitch <= cfg_data[30:0];
          rvli_pkg::CFG_PLANAR: planar_mode <= cfg_data[0];
          rvli_pkg::CFG_SLICES: slice_count <= cfg_data[6:0];
          default: ;
        endcase
      end

      case (state)
        // ray transfer: latch geometry and clear the sums
        ST_IDLE: begin
          if (in_acc && kind == rvli_pkg::KIND_RAY) begin
            s_reg[0] <= src_x;
            s_reg[1] <= src_y;
            s_reg[2] <= src_z;
            for (int a = 0; a < 3; a++) begin
              dmag[a] <= dfull[a][32] ? 33'(-dfull[a]) : 33'(dfull[a]);
              dneg[a] <= dfull[a][32];
              dnz[a]  <= (dfull[a] != '0);
            end
            planar_r <= planar_mode;
            if (planar_mode) begin
              slices <= (slice_count == 7'd0) ? 7'd1
                      : (slice_count > 7'd64) ? 7'd64 : slice_count;
            end else begin
              slices <= 7'd1;
            end
            sum_vld <= '0;
            sqacc   <= '0;
            ax      <= 2'd0;
            done    <= 3'b111;
            k       <= '0;
            state   <= (voxel_pitch == '0) ? ST_OUT_RD : ST_SQ_MUL;
          end
        end

        // squared length, then its root
        ST_SQ_MUL: begin
          state <= (ax == naxes) ? ST_SQRT : ST_SQ_ACC;
        end
        ST_SQ_ACC: begin
          sqacc <= sqacc + rvli_pkg::SQ_W'(prod[64:0]);
          ax    <= ax + 2'd1;
          state <= ST_SQ_MUL;
        end
        ST_SQRT: begin
          if (sq_stat.done) begin
            len   <= sq_root;
            ax    <= 2'd0;
            state <= ST_PN_MUL;
          end
        end

        // pitch times extent per axis, and the slice plane size
        ST_PN_MUL: begin
          state <= (ax == 2'd3) ? ST_PS_MUL : ST_PN_ST;
        end
        ST_PN_ST: begin
          pn[ax] <= prod[39:0];
          ax     <= ax + 2'd1;
          state  <= ST_PN_MUL;
        end
        ST_PS_MUL: state <= ST_PS_ST;
        ST_PS_ST: begin
          plane_sz <= prod[16:0];
          ax       <= 2'd0;
          amin     <= '0;
          amax     <= rvli_pkg::ONE_Q31;
          state    <= ST_BND;
        end

        // entry and exit parameters
        ST_BND: begin
          if (ax == naxes) begin
            ax    <= 2'd0;
            k     <= '0;
            state <= (amin >= amax) ? ST_OUT_RD : ST_INIT;
          end else if (!dnz[ax]) begin
            ax <= ax + 2'd1;
          end else begin
            al_m  <= '0;
            ret   <= ST_BND_F;
            state <= ST_AL_MUL;
          end
        end
        ST_BND_F: begin
          ftmp  <= al_res;
          al_m  <= dim[ax];
          ret   <= ST_BND_L;
          state <= ST_AL_MUL;
        end
        ST_BND_L: begin
          if (((ftmp < al_res) ? ftmp : al_res) > amin) begin
            amin <= (ftmp < al_res) ? ftmp : al_res;
          end
          if (((ftmp > al_res) ? ftmp : al_res) < amax) begin
            amax <= (ftmp > al_res) ? ftmp : al_res;
          end
          ax    <= ax + 2'd1;
          state <= ST_BND;
        end

        // crossing parameter of plane al_m on axis ax
        ST_AL_MUL: state <= ST_AL_NUM;
        ST_AL_NUM: begin
          if (num == '0 || num[41] != dneg[ax]) begin
            al_res <= '0;
            state  <= ret;
          end else if (nmag >= {8'b0, den2}) begin
            al_res <= rvli_pkg::ONE_Q31;
            state  <= ret;
          end else begin
            state <= ST_AL_DIV;
          end
        end
        ST_AL_DIV: begin
          if (div_stat.done) begin
            al_res <= {1'b0, div_q};
            state  <= ret;
          end
        end

        // first crossing per moving axis
        ST_INIT: begin
          if (ax == naxes) begin
            prev  <= amin;
            state <= ST_SEL;
          end else if (!dnz[ax]) begin
            ax <= ax + 2'd1;
          end else begin
            m_r[ax]  <= dneg[ax] ? dim[ax] : 9'd0;
            al_m     <= dneg[ax] ? dim[ax] : 9'd0;
            done[ax] <= 1'b0;
            ret      <= ST_INIT_ST;
            state    <= ST_AL_MUL;
          end
        end
        ST_INIT_ST: begin
          cand[ax] <= al_res;
          ax       <= ax + 2'd1;
          state    <= ST_INIT;
        end

        // merge the per-axis crossing streams in order
        ST_SEL: begin
          if (!sel_ok) begin
            cur     <= amax;
            fin_seg <= 1'b1;
            state   <= ST_SEG;
          end else if (sel_c <= amin) begin
            sel   <= sel_ax;
            state <= ST_ADV;
          end else if (sel_c >= amax) begin
            done[sel_ax] <= 1'b1;
          end else begin
            sel     <= sel_ax;
            cur     <= sel_c;
            fin_seg <= 1'b0;
            state   <= ST_SEG;
          end
        end
        ST_SEG: begin
          if (cur <= prev) begin
            k     <= '0;
            state <= fin_seg ? ST_OUT_RD : ST_ADV;
          end else begin
            asum  <= {1'b0, prev} + {1'b0, cur};
            ax    <= 2'd0;
            state <= ST_IX_MUL;
          end
        end

        // voxel index per axis at the segment midpoint
        ST_IX_MUL: begin
          state <= (ax == naxes) ? ST_AD_SUM : ST_IX_REL;
        end
        ST_IX_REL: begin
          if (rel[42] || rel >= $signed({2'b0, pn[ax], 1'b0})) begin
            prev  <= cur;
            k     <= '0;
            state <= fin_seg ? ST_OUT_RD : ST_ADV;
          end else begin
            state <= ST_IX_DIV;
          end
        end
        ST_IX_DIV: begin
          if (div_stat.done) begin
            idx[ax] <= div_q[7:0];
            ax      <= ax + 2'd1;
            state   <= ST_IX_MUL;
          end
        end

        // linear voxel address
        ST_AD_SUM: begin
          ad    <= VA_W'(prod) + VA_W'(idx[0]);
          state <= planar_r ? ST_SL_MUL : ST_AD3_MUL;
        end
        ST_AD3_MUL: state <= ST_AD3_SUM;
        ST_AD3_SUM: begin
          ad    <= VA_W'(prod) + ad;
          state <= ST_SL_MUL;
        end

        // segment length
        ST_SL_MUL: state <= ST_SL_ST;
        ST_SL_ST: begin
          sl <= prod[65:31];
          k  <= '0;
          if (planar_r) begin
            kend <= ({2'b0, slices} > dim[2]) ? dim[2][6:0] : slices;
          end else begin
            kend <= 7'd1;
          end
          state <= ST_ACC_RD;
        end

        // weighted voxel into each slice sum
        ST_ACC_RD: begin
          if (k < kend) begin
            state <= ST_ACC_MUL;
          end else begin
            prev  <= cur;
            k     <= '0;
            state <= fin_seg ? ST_OUT_RD : ST_ADV;
          end
        end
        ST_ACC_MUL: state <= ST_ACC_WR;
        ST_ACC_WR: begin
          sum_vld[k[rvli_pkg::SLICE_AW-1:0]] <= 1'b1;
          k     <= k + 7'd1;
          ad    <= ad + VA_W'(plane_sz);
          state <= ST_ACC_RD;
        end

        // step the chosen axis to its next plane
        ST_ADV: begin
          if (dneg[sel] ? (m_r[sel] == 9'd0) : (m_r[sel] == dim[sel])) begin
            done[sel] <= 1'b1;
            state     <= ST_SEL;
          end else begin
            m_r[sel] <= m_step;
            al_m     <= m_step;
            ax       <= sel;
            ret      <= ST_ADV_ST;
            state    <= ST_AL_MUL;
          end
        end
        ST_ADV_ST: begin
          cand[sel] <= al_res;
          state     <= ST_SEL;
        end

        // result transfers, one per slice
        ST_OUT_RD: state <= ST_OUT_LD;
        ST_OUT_LD: begin
          line_integral <= sum_vld[k[rvli_pkg::SLICE_AW-1:0]] ? sum_rd : '0;
          slice_index   <= planar_r ? k[5:0] : 6'd0;
          last          <= (k + 7'd1 == slices);
          state         <= ST_OUT_SHOW;
        end
        ST_OUT_SHOW: begin
          if (out_ready) begin
            k     <= k + 7'd1;
            state <= last ? ST_IDLE : ST_OUT_RD;
          end
        end

        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  // the walk only runs over a non-empty parameter range
  a_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_SEL |-> amin < amax) else $error("empty range in walk");

  // index work only for segments of positive length
  a_seg: assert property (@(posedge clk) disable iff (rst)
    state == ST_IX_MUL |-> prev < cur) else $error("zero-length segment");

  // divider is never restarted while busy
  a_div: assert property (@(posedge clk) disable iff (rst)
    div_req.start |-> !div_stat.busy) else $error("divider restarted");

  // sums are written only within the slice range of the segment
  a_acc: assert property (@(posedge clk) disable iff (rst)
    sum_we |-> k < kend) else $error("sum write out of range");

  // the final transfer carries the last slice
  a_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && last |-> slice_index == (planar_r ? 6'(slices - 7'd1) : 6'd0))
    else $error("last flag on wrong slice");
`endif

endmodule
`default_nettype wire

// ===== dv/tb.sv =====
// self-checking testbench of ray_volume_line_integral (forward projector)
// depends on rvli_pkg and the block RTL; line integrals predicted in-bench
`timescale 1ns / 1ps
module tb;
  import rvli_pkg::*;

  localparam int ONE = 65536;
  localparam int VOL_WORDS = 262144;

  typedef struct packed {
    logic               kind;
    logic [17:0]        addr;
    logic [15:0]        val;
    logic signed [31:0] sx, sy, sz, dx, dy, dz;
  } item_t;

  typedef struct packed {
    logic [47:0] integral;
    logic [5:0]  slice;
    logic        fin;
  } proj_t;

  // directed row: typed expectation only where it is obvious
  typedef struct packed {
    item_t       it;
    logic        typed;
    logic [47:0] tval;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0, in_ready;
  logic kind = KIND_LOAD;
  logic [17:0] voxel_address = '0;
  logic [15:0] voxel_value = '0;
  logic signed [31:0] src_x = '0, src_y = '0, src_z = '0;
  logic signed [31:0] det_x = '0, det_y = '0, det_z = '0;
  logic out_valid, out_ready = 1'b0;
  logic [47:0] line_integral;
  logic [5:0] slice_index;
  logic last;
  logic cfg_valid = 1'b0, cfg_ready;
  logic [2:0] cfg_index = CFG_SIZE_X;
  logic [31:0] cfg_data = '0;

  // shadow of the block's registers and volume
  logic [6:0]  sz_x = 7'd64, sz_y = 7'd64, sz_z = 7'd64, slice_req = 7'd64;
  logic [30:0] pitch_q16 = 31'd65536;
  logic        planar_on = 1'b0;
  logic [15:0] vox_mem [0:VOL_WORDS-1];

  proj_t proj_q[$];
  int errors = 0, n_rays = 0, n_loads = 0, n_results = 0;
  bit quiet = 1'b0;
  bit hold_pending = 1'b0;

  ray_volume_line_integral u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .kind(kind),
    .voxel_address(voxel_address), .voxel_value(voxel_value),
    .src_x(src_x), .src_y(src_y), .src_z(src_z),
    .det_x(det_x), .det_y(det_y), .det_z(det_z),
    .out_valid(out_valid), .out_ready(out_ready),
    .line_integral(line_integral), .slice_index(slice_index), .last(last),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #20_000_000;
    $display("timeout at %0t", $time);
    $display("** ray_volume_line_integral: FAILED **");
    $finish;
  end

  // ---------------- line integral predictor ----------------

  function automatic logic [63:0] frac_mul(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[94:31];
  endfunction

  // crossing parameter num/den, clamped to [0,1] in Q1.31
  function automatic logic [31:0] cross_param(longint num, longint den);
    longint unsigned nm, dn;
    logic [127:0] q;
    if (num == 0 || ((num < 0) != (den < 0))) return 32'd0;
    nm = num < 0 ? -num : num;
    dn = den < 0 ? -den : den;
    if (nm >= dn) return ONE_Q31;
    q = ({64'd0, nm} << 31) / {64'd0, dn};
    return q[31:0];
  endfunction

  function automatic logic [63:0] ray_length(logic [127:0] v);
    logic [71:0] root, rem, trial;
    root = '0;
    rem = '0;
    for (int i = 34; i >= 0; i--) begin
      rem = (rem << 2) | v[2*i +: 2];
      trial = (root << 2) | 1;
      if (rem >= trial) begin
        rem = rem - trial;
        root = (root << 1) | 1;
      end else begin
        root = root << 1;
      end
    end
    return root[63:0];
  endfunction

  function automatic longint plane_pos(int m, int n);
    return longint'(pitch_q16) * (2 * longint'(m) - longint'(n));
  endfunction

  // voxel index along one axis at a segment midpoint, -1 when outside
  function automatic int mid_voxel(longint s, longint d, logic [63:0] asum, int n);
    longint off, rel, idx;
    off = longint'(frac_mul(asum, d < 0 ? -d : d));
    rel = 2 * s + (d < 0 ? -off : off) + longint'(pitch_q16) * n;
    if (rel < 0) return -1;
    idx = rel / (longint'(pitch_q16) * 2);
    return idx >= n ? -1 : int'(idx);
  endfunction

  task automatic predict_ray(item_t it);
    longint s[3], d[3];
    int dim[3], idx[3];
    int naxes, slices, plane_sz, base, ad;
    logic [63:0] sums[64];
    logic [31:0] amin, amax, f, l, t, prev, cur;
    logic [31:0] xq[$];
    logic [127:0] sq;
    logic [63:0] len, sl, c;
    bit ok;
    proj_t r;
    s[0] = it.sx; s[1] = it.sy; s[2] = it.sz;
    d[0] = longint'(it.dx) - s[0];
    d[1] = longint'(it.dy) - s[1];
    d[2] = longint'(it.dz) - s[2];
    dim[0] = sz_x > 64 ? 64 : sz_x;
    dim[1] = sz_y > 64 ? 64 : sz_y;
    dim[2] = sz_z > 64 ? 64 : sz_z;
    naxes = planar_on ? 2 : 3;
    slices = 1;
    if (planar_on) slices = slice_req == 0 ? 1 : (slice_req > 64 ? 64 : slice_req);
    foreach (sums[k]) sums[k] = '0;
    if (pitch_q16 != 0) begin : trace
      amin = 0;
      amax = ONE_Q31;
      for (int a = 0; a < naxes; a++) begin
        if (d[a] == 0) continue;
        f = cross_param(plane_pos(0, dim[a]) - 2 * s[a], 2 * d[a]);
        l = cross_param(plane_pos(dim[a], dim[a]) - 2 * s[a], 2 * d[a]);
        if ((f < l ? f : l) > amin) amin = f < l ? f : l;
        if ((f > l ? f : l) < amax) amax = f > l ? f : l;
      end
      if (amin >= amax) disable trace;
      for (int a = 0; a < naxes; a++) begin
        if (d[a] == 0) continue;
        for (int m = 0; m <= dim[a]; m++) begin
          t = cross_param(plane_pos(m, dim[a]) - 2 * s[a], 2 * d[a]);
          if (t > amin && t < amax) xq.push_back(t);
        end
      end
      xq.sort();
      sq = '0;
      for (int a = 0; a < naxes; a++)
        sq = sq + 128'(d[a] < 0 ? -d[a] : d[a]) * 128'(d[a] < 0 ? -d[a] : d[a]);
      len = ray_length(sq);
      plane_sz = dim[0] * dim[1];
      prev = amin;
      for (int i = 0; i <= xq.size(); i++) begin
        cur = i < xq.size() ? xq[i] : amax;
        if (cur <= prev) continue;
        ok = 1'b1;
        for (int a = 0; a < naxes; a++) begin
          idx[a] = mid_voxel(s[a], d[a], 64'(prev) + 64'(cur), dim[a]);
          if (idx[a] < 0) ok = 1'b0;
        end
        if (ok) begin
          sl = frac_mul(64'(cur - prev), len);
          base = idx[1] * dim[0] + idx[0];
          for (int k = 0; k < (naxes == 3 ? 1 : slices) && (naxes == 3 || k < dim[2]); k++) begin
            ad = naxes == 3 ? idx[2] * plane_sz + base : k * plane_sz + base;
            if (ad < VOL_WORDS) begin
              c = sums[k] + 64'(vox_mem[ad]) * sl;
              sums[k] = c > 64'(SUM_MAX) ? 64'(SUM_MAX) : c;
            end
          end
        end
        prev = cur;
      end
    end
    for (int k = 0; k < slices; k++) begin
      r.integral = sums[k][47:0];
      r.slice = planar_on ? 6'(k) : 6'd0;
      r.fin = (k + 1 == slices);
      proj_q.push_back(r);
    end
  endtask

  // ---------------- stimulus ----------------

  // one input transfer; the shadow is updated at the accepting edge
  task automatic send_item(item_t it, logic typed = 1'b0, logic [47:0] tval = '0);
    proj_t r;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid <= 1'b1;
    kind <= it.kind;
    voxel_address <= it.addr;
    voxel_value <= it.val;
    src_x <= it.sx; src_y <= it.sy; src_z <= it.sz;
    det_x <= it.dx; det_y <= it.dy; det_z <= it.dz;
    do @(posedge clk); while (!in_ready);
    if (it.kind == KIND_LOAD) begin
      vox_mem[it.addr] = it.val;
      n_loads++;
    end else begin
      n_rays++;
      if (typed) begin
        r.integral = tval;
        r.slice = '0;
        r.fin = 1'b1;
        proj_q.push_back(r);
      end else begin
        predict_ray(it);
      end
    end
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (proj_q.size() != 0) @(posedge clk);
    // a final load may still be in flight
    repeat (50) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_SIZE_X: sz_x = data[6:0];
      CFG_SIZE_Y: sz_y = data[6:0];
      CFG_SIZE_Z: sz_z = data[6:0];
      CFG_PITCH:  pitch_q16 = data[30:0];
      CFG_PLANAR: planar_on = data[0];
      CFG_SLICES: slice_req = data[6:0];
      default: ;
    endcase
  endtask

  function automatic item_t make_load(int a, logic [15:0] v);
    item_t it;
    it = '0;
    it.kind = KIND_LOAD;
    it.addr = 18'(a);
    it.val = v;
    return it;
  endfunction

  // random ray, mostly around the box so that it crosses many planes
  function automatic item_t rand_ray();
    item_t it;
    longint sp, c[6];
    int n, a;
    n = sz_x > sz_y ? sz_x : sz_y;
    n = sz_z > n ? sz_z : n;
    if (n > 64) n = 64;
    if (n < 1) n = 1;
    sp = longint'(pitch_q16) * n;
    if (sp > 64'sh7FFF_FFFF) sp = 64'sh7FFF_FFFF;
    if (sp < 16) sp = 16;
    for (int i = 0; i < 6; i++)
      c[i] = $urandom_range(0, 9) == 0 ? longint'(int'($urandom))
           : (longint'($urandom) % (2 * sp + 1)) - sp;
    if ($urandom_range(0, 3) == 0) begin
      a = $urandom_range(0, 2);
      c[3 + a] = c[a];
    end
    if ($urandom_range(0, 24) == 0) for (int i = 0; i < 3; i++) c[3 + i] = c[i];
    it = '0;
    it.kind = KIND_RAY;
    it.sx = c[0]; it.sy = c[1]; it.sz = c[2];
    it.dx = c[3]; it.dy = c[4]; it.dz = c[5];
    return it;
  endfunction

  // program all registers, load the whole volume in use, trace random rays
  task automatic run_phase(int x, int y, int z, logic [31:0] pitch, int pl, int sc,
                           int rays, bit hold = 1'b0);
    int nvox;
    wait_idle();
    write_reg(CFG_SIZE_X, 32'(x) | 32'hFFFF_FF80 & {32{pl[0]}});
    write_reg(CFG_SIZE_Y, 32'(y));
    write_reg(CFG_SIZE_Z, 32'(z));
    write_reg(CFG_PITCH, pitch);
    write_reg(CFG_PLANAR, 32'(pl));
    write_reg(CFG_SLICES, 32'(sc));
    nvox = (sz_x > 64 ? 64 : sz_x) * (sz_y > 64 ? 64 : sz_y) * (sz_z > 64 ? 64 : sz_z);
    for (int a = 0; a < nvox; a++)
      send_item(make_load(a, $urandom_range(0, 7) == 0 ? 16'hFFFF : 16'($urandom)));
    if (hold) hold_pending = 1'b1;
    for (int i = 0; i < rays; i++) begin
      if ($urandom_range(0, 9) == 0)
        send_item(make_load($urandom_range(0, VOL_WORDS - 1), 16'($urandom)));
      send_item(rand_ray());
    end
  endtask

  function automatic stim_row_t ray_row(int sx, int sy, int sz, int dx, int dy, int dz,
                                        logic typed = 1'b0);
    stim_row_t r;
    r = '0;
    r.it.kind = KIND_RAY;
    r.it.sx = sx; r.it.sy = sy; r.it.sz = sz;
    r.it.dx = dx; r.it.dy = dy; r.it.dz = dz;
    r.typed = typed;
    return r;
  endfunction

  function automatic stim_row_t load_row(int a, int v);
    stim_row_t r;
    r = '0;
    r.it = make_load(a, 16'(v));
    return r;
  endfunction

  // ---------------- result checking ----------------

  always @(posedge clk) begin
    proj_t e;
    if (out_valid && out_ready) begin
      n_results++;
      if (proj_q.size() == 0) begin
        $display("%0t: unexpected result integral=%h slice=%0d last=%b",
                 $time, line_integral, slice_index, last);
        errors++;
      end else begin
        e = proj_q.pop_front();
        if (line_integral !== e.integral) begin
          $display("%0t: line_integral expected %h actual %h", $time, e.integral,
                   line_integral);
          errors++;
        end
        if (slice_index !== e.slice) begin
          $display("%0t: slice_index expected %0d actual %0d", $time, e.slice,
                   slice_index);
          errors++;
        end
        if (last !== e.fin) begin
          $display("%0t: last expected %b actual %b", $time, e.fin, last);
          errors++;
        end
      end
    end
  end

  // receiver: random stall bursts, one long hold-off on request
  initial begin
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_pending) begin
        out_ready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_pending = 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 8) - 1) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 12) - 1) @(posedge clk);
      end
    end
  end

  // ---------------- main sequence ----------------

  initial begin
    stim_row_t dir_rows[$];
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // ray far outside the default box reads nothing
    send_item(ray_row(200*ONE, 200*ONE, 200*ONE, 300*ONE, 300*ONE, 300*ONE).it,
              1'b1, 48'd0);

    run_phase(4, 4, 4, ONE, 0, 1, 0);
    dir_rows = '{
      ray_row(10*ONE, 10*ONE, 10*ONE, 20*ONE, 20*ONE, 20*ONE, 1'b1),
      ray_row(ONE/2, ONE/2, ONE/2, ONE/2, ONE/2, ONE/2, 1'b1),
      load_row(0, 'hFFFF),
      load_row(VOL_WORDS - 1, 0),
      load_row('h15555, 'hAAAA),
      load_row('h2AAAA, 'h5555),
      load_row(63, 'h0100),
      ray_row(-3*ONE, ONE/4, ONE/4, 3*ONE, ONE/4, ONE/4),
      ray_row(-3*ONE, -3*ONE, -3*ONE, 3*ONE, 3*ONE, 3*ONE),
      ray_row(3*ONE, 3*ONE, 3*ONE, -3*ONE, -3*ONE, -3*ONE),
      ray_row(ONE/10, ONE/5, ONE/3, 5*ONE, -4*ONE, ONE),
      ray_row(-ONE, ONE/3, ONE/7, ONE, -ONE/2, ONE/9),
      ray_row(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
              32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF),
      ray_row(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF,
              32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000),
      ray_row(-5*ONE, 0, ONE/2, 5*ONE, 0, ONE/2),
      ray_row(-5*ONE, -2*ONE, ONE/2, 5*ONE, -2*ONE, ONE/2),
      ray_row(ONE/2, -ONE/2, 6*ONE, ONE/2, -ONE/2, -6*ONE),
      ray_row(-5*ONE, 2*ONE - 1, 0, 5*ONE, -2*ONE + 1, 1)
    };
    foreach (dir_rows[i])
      send_item(dir_rows[i].it, dir_rows[i].typed, dir_rows[i].tval);

    // random phases over register settings, extremes included
    run_phase(3, 5, 2, 32'h0001_8000, 0, 64, 14);
    run_phase(1, 1, 64, ONE, 1, 64, 8, 1'b1);
    run_phase(4, 4, 2, 32'hFFFF_FFFF, 1, 0, 14);
    run_phase(3, 4, 3, 32'h0000_4000, 1, 100, 14);
    run_phase(0, 4, 4, ONE, 0, 5, 10);
    run_phase(100, 1, 1, 1, 0, 1, 12);
    run_phase(2, 2, 2, 0, 1, 3, 8);
    wait_idle();
    quiet = 1'b1;
    run_phase(2, 2, 2, 32'h0002_0000, 0, 1, 14);

    in_valid <= 1'b0;
    while (proj_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("run: %0d rays and %0d voxel loads traced, %0d integrals checked",
             n_rays, n_loads, n_results);
    $display("settings: 3-D and planar, sizes 0..100, pitch 0..max, slices 0..100");
    if (errors == 0) begin
      $display("** ray_volume_line_integral: PASSED **");
    end else begin
      $display("** ray_volume_line_integral: FAILED **");
    end
    $finish;
  end

endmodule
